FILE: hdl/assert_macros.svh
// assertion helpers used by the aps_engine rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define APS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("aps assertion failed");

// antecedent in one cycle implies consequent in the next
`define APS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aps assertion failed");

`endif

FILE: hdl/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// shared types, codes and helpers of the aabb physics step unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aps_pkg;

  localparam int NumBodiesDef = 16;
  localparam int NumBoxesDef  = 32;

  localparam int InDataW  = 232;
  localparam int OutDataW = 136;

  // input command codes
  localparam logic [1:0] CMD_LOAD_BODY = 2'd0;
  localparam logic [1:0] CMD_LOAD_BOX  = 2'd1;
  localparam logic [1:0] CMD_TICK      = 2'd2;

  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_BOX,
    KIND_TICK
  } aps_kind_e;

  typedef struct packed {
    aps_kind_e          kind;
    logic [7:0]         slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic signed [15:0] gravity_scale;
    logic               use_gravity;
    logic [15:0]        dt;
  } aps_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLOAD,
    ST_G1X,
    ST_G2X,
    ST_GVX,
    ST_G1Y,
    ST_G2Y,
    ST_GVY,
    ST_P1X,
    ST_PPX,
    ST_P1Y,
    ST_PPY,
    ST_DIFF,
    ST_OVL,
    ST_RES,
    ST_EMIT
  } aps_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
    logic signed [31:0] r;
    if (x > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/aps_front.sv
// ----------------------------------------------------------------------------
// aps_front
// accepts input items, drops those that do nothing, queues the rest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aps_front #(
  parameter int NUM_BODIES = aps_pkg::NumBodiesDef,
  parameter int NUM_BOXES  = aps_pkg::NumBoxesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire logic [1:0]                   s_cmd_i,
  input  wire logic [aps_pkg::InDataW-1:0]  s_data_i,
  output logic                              q_valid_o,
  input  wire logic                         q_ready_i,
  output aps_pkg::aps_item_t                q_item_o
);
  import aps_pkg::*;

  aps_item_t  fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  aps_item_t  item;
  logic       keep, push, pop;

  always_comb begin
    item.slot          = s_data_i[7:0];
    item.pos_x         = s_data_i[39:8];
    item.pos_y         = s_data_i[71:40];
    item.vel_x         = s_data_i[103:72];
    item.vel_y         = s_data_i[135:104];
    item.half_x        = s_data_i[166:136];
    item.half_y        = s_data_i[197:167];
    item.gravity_scale = s_data_i[213:198];
    item.use_gravity   = s_data_i[214];
    item.dt            = s_data_i[230:215];
    item.kind          = KIND_TICK;
    keep               = 1'b0;
    unique case (s_cmd_i)
      CMD_LOAD_BODY: begin
        item.kind = KIND_BODY;
        keep      = ({1'b0, s_data_i[7:0]} < 9'(NUM_BODIES));
      end
      CMD_LOAD_BOX: begin
        item.kind = KIND_BOX;
        keep      = ({1'b0, s_data_i[7:0]} < 9'(NUM_BOXES));
      end
      CMD_TICK: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = fifo_q[rp_q];
  assign push      = s_valid_i && s_ready_o && keep;
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= item;
  end

endmodule
`default_nettype wire

FILE: hdl/aps_engine.sv
// ----------------------------------------------------------------------------
// aps_engine
// executes queued loads and ticks: slot stores, integrator and box sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aps_engine #(
  parameter int NUM_BODIES = aps_pkg::NumBodiesDef,
  parameter int NUM_BOXES  = aps_pkg::NumBoxesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic signed [31:0]           gravity_x_i,
  input  wire logic signed [31:0]           gravity_y_i,
  input  wire logic                         q_valid_i,
  output logic                              q_ready_o,
  input  wire aps_pkg::aps_item_t           q_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [aps_pkg::OutDataW-1:0]      out_data_o,
  output logic                              out_last_o
);
  import aps_pkg::*;

  localparam int BW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
  localparam int XW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam logic [BW-1:0] LastBody = BW'(NUM_BODIES - 1);
  localparam logic [XW-1:0] LastBox  = XW'(NUM_BOXES - 1);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic signed [15:0] gs;
    logic               gon;
  } body_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [30:0]        hx;
    logic [30:0]        hy;
  } box_t;

  body_t body_m [NUM_BODIES];
  box_t  box_m [NUM_BOXES];
  body_t body_rd_q;
  box_t  box_rd_q;

  logic [NUM_BODIES-1:0] body_valid_q, body_valid_d;
  logic [NUM_BOXES-1:0]  box_valid_q, box_valid_d;

  aps_state_e state_q, state_d;
  logic [BW-1:0] i_q, i_d;
  logic [XW-1:0] j_q, j_d;
  logic [15:0]   dt_q, dt_d;

  logic signed [31:0] px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d;
  logic               gr_q, gr_d;
  logic signed [57:0] p_q;
  logic signed [40:0] mul_a;
  logic signed [16:0] mul_b;
  logic [32:0]        adx_q, adx_d, ady_q, ady_d;
  logic               gtx_q, gtx_d, gty_q, gty_d;
  logic signed [33:0] ox_q, ox_d, oy_q, oy_d;
  logic signed [32:0] dx, dy;
  logic               hit, more;
  logic               emit_go;

  logic                ov_q;
  logic [OutDataW-1:0] od_q;
  logic                ol_q;

  logic    body_we, box_we;
  logic [BW-1:0] body_wa;
  logic [XW-1:0] box_wa;
  body_t   body_wd;
  box_t    box_wd;

  assign emit_go   = !ov_q || out_ready_i;
  assign q_ready_o = (state_q == ST_IDLE);

  // any valid body above the current one
  always_comb begin
    more = 1'b0;
    for (int k = 0; k < NUM_BODIES; k++) begin
      if (k > int'(i_q) && body_valid_q[k]) more = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_item_i.kind == KIND_TICK) state_d = ST_BLOAD;
      end
      ST_BLOAD: begin
        if (body_valid_q[i_q]) begin
          state_d = body_rd_q.gon ? ST_G1X : ST_P1X;
        end else if (i_q == LastBody) begin
          state_d = ST_IDLE;
        end
      end
      ST_G1X: state_d = ST_G2X;
      ST_G2X: state_d = ST_GVX;
      ST_GVX: state_d = ST_G1Y;
      ST_G1Y: state_d = ST_G2Y;
      ST_G2Y: state_d = ST_GVY;
      ST_GVY: state_d = ST_P1X;
      ST_P1X: state_d = ST_PPX;
      ST_PPX: state_d = ST_P1Y;
      ST_P1Y: state_d = ST_PPY;
      ST_PPY: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_OVL;
      ST_OVL: state_d = ST_RES;
      ST_RES: state_d = (j_q == LastBox) ? ST_EMIT : ST_DIFF;
      ST_EMIT: begin
        if (emit_go) state_d = (i_q == LastBody) ? ST_IDLE : ST_BLOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = 41'(gravity_x_i);
    mul_b = 17'(body_rd_q.gs);
    case (state_q)
      ST_G1Y: mul_a = 41'(gravity_y_i);
      ST_G2X, ST_G2Y: begin
        mul_a = p_q[48:8];
        mul_b = signed'({1'b0, dt_q});
      end
      ST_P1X: begin
        mul_a = 41'(vx_q);
        mul_b = signed'({1'b0, dt_q});
      end
      ST_P1Y: begin
        mul_a = 41'(vy_q);
        mul_b = signed'({1'b0, dt_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    dx  = 33'(px_q) - 33'(box_rd_q.px);
    dy  = 33'(py_q) - 33'(box_rd_q.py);
    hit = box_valid_q[j_q] && (ox_q > 34'sd0) && (oy_q > 34'sd0);
  end

  // datapath and store control
  always_comb begin
    i_d = i_q;
    j_d = j_q;
    dt_d = dt_q;
    px_d = px_q;
    py_d = py_q;
    vx_d = vx_q;
    vy_d = vy_q;
    gr_d = gr_q;
    adx_d = adx_q;
    ady_d = ady_q;
    gtx_d = gtx_q;
    gty_d = gty_q;
    ox_d = ox_q;
    oy_d = oy_q;
    body_valid_d = body_valid_q;
    box_valid_d = box_valid_q;
    body_we = 1'b0;
    box_we = 1'b0;
    body_wa = i_q;
    box_wa = q_item_i.slot[XW-1:0];
    body_wd.px  = px_q;
    body_wd.py  = py_q;
    body_wd.vx  = vx_q;
    body_wd.vy  = vy_q;
    body_wd.hx  = body_rd_q.hx;
    body_wd.hy  = body_rd_q.hy;
    body_wd.gs  = body_rd_q.gs;
    body_wd.gon = body_rd_q.gon;
    box_wd.px = q_item_i.pos_x;
    box_wd.py = q_item_i.pos_y;
    box_wd.hx = q_item_i.half_x;
    box_wd.hy = q_item_i.half_y;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.kind)
            KIND_BODY: begin
              body_we     = 1'b1;
              body_wa     = q_item_i.slot[BW-1:0];
              body_wd.px  = q_item_i.pos_x;
              body_wd.py  = q_item_i.pos_y;
              body_wd.vx  = q_item_i.vel_x;
              body_wd.vy  = q_item_i.vel_y;
              body_wd.hx  = q_item_i.half_x;
              body_wd.hy  = q_item_i.half_y;
              body_wd.gs  = q_item_i.gravity_scale;
              body_wd.gon = q_item_i.use_gravity;
              body_valid_d[q_item_i.slot[BW-1:0]] = 1'b1;
            end
            KIND_BOX: begin
              box_we = 1'b1;
              box_valid_d[q_item_i.slot[XW-1:0]] = 1'b1;
            end
            default: begin
              i_d  = '0;
              dt_d = q_item_i.dt;
            end
          endcase
        end
      end
      ST_BLOAD: begin
        if (body_valid_q[i_q]) begin
          px_d = body_rd_q.px;
          py_d = body_rd_q.py;
          vx_d = body_rd_q.vx;
          vy_d = body_rd_q.vy;
          gr_d = 1'b0;
          j_d  = '0;
        end else if (i_q != LastBody) begin
          i_d = i_q + BW'(1);
        end
      end
      ST_GVX: vx_d = sat32(44'(vx_q) + 44'($signed(p_q[57:16])));
      ST_GVY: vy_d = sat32(44'(vy_q) + 44'($signed(p_q[57:16])));
      ST_PPX: px_d = sat32(44'(px_q) + 44'($signed(p_q[57:16])));
      ST_PPY: py_d = sat32(44'(py_q) + 44'($signed(p_q[57:16])));
      ST_DIFF: begin
        adx_d = dx[32] ? 33'(-dx) : 33'(dx);
        ady_d = dy[32] ? 33'(-dy) : 33'(dy);
        gtx_d = (px_q > box_rd_q.px);
        gty_d = (py_q > box_rd_q.py);
      end
      ST_OVL: begin
        ox_d = signed'({3'b0, body_rd_q.hx}) + signed'({3'b0, box_rd_q.hx})
             - signed'({1'b0, adx_q});
        oy_d = signed'({3'b0, body_rd_q.hy}) + signed'({3'b0, box_rd_q.hy})
             - signed'({1'b0, ady_q});
      end
      ST_RES: begin
        if (hit) begin
          // y only when strictly shallower, equal centres push negative
          if (oy_q < ox_q) begin
            if (gty_q) begin
              py_d = sat32(44'(py_q) + 44'(oy_q));
              gr_d = 1'b1;
            end else begin
              py_d = sat32(44'(py_q) - 44'(oy_q));
            end
            vy_d = '0;
          end else begin
            if (gtx_q) px_d = sat32(44'(px_q) + 44'(ox_q));
            else px_d = sat32(44'(px_q) - 44'(ox_q));
            vx_d = '0;
          end
        end
        if (j_q != LastBox) j_d = j_q + XW'(1);
      end
      ST_EMIT: begin
        if (emit_go) begin
          body_we = 1'b1;
          if (i_q != LastBody) i_d = i_q + BW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      body_valid_q <= '0;
      box_valid_q  <= '0;
      i_q          <= '0;
      j_q          <= '0;
      ov_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      body_valid_q <= body_valid_d;
      box_valid_q  <= box_valid_d;
      i_q          <= i_d;
      j_q          <= j_d;
      if (state_q == ST_EMIT && emit_go) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q  <= dt_d;
    px_q  <= px_d;
    py_q  <= py_d;
    vx_q  <= vx_d;
    vy_q  <= vy_d;
    gr_q  <= gr_d;
    adx_q <= adx_d;
    ady_q <= ady_d;
    gtx_q <= gtx_d;
    gty_q <= gty_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    p_q   <= mul_a * mul_b;
    if (state_q == ST_EMIT && emit_go) begin
      od_q <= {1'b0, gr_q, vy_q, vx_q, py_q, px_q, 6'(i_q)};
      ol_q <= !more;
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_we) body_m[body_wa] <= body_wd;
    if (box_we) box_m[box_wa] <= box_wd;
    body_rd_q <= body_m[i_d];
    box_rd_q  <= box_m[j_d];
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_last_o  = ol_q;

  `APS_ASSERT(a_box_idx_range, j_q <= LastBox)
  `APS_ASSERT(a_rose_from_emit, $rose(ov_q) |-> $past(state_q == ST_EMIT))
  `APS_ASSERT_NEXT(a_res_next, state_q == ST_RES, state_q == ST_DIFF || state_q == ST_EMIT)
  `APS_ASSERT(a_busy_no_load, (state_q != ST_IDLE && state_q != ST_EMIT) |-> !body_we)

endmodule
`default_nettype wire

FILE: hdl/aabb_physics_step_unit.sv
// ----------------------------------------------------------------------------
// aabb_physics_step_unit
// fixed-point 2d body integration with axis-aligned box collision push-out
// ----------------------------------------------------------------------------
// Loads pass through a two-entry command queue into the slot stores. A tick
// walks the body slots in order: an empty slot is skipped in the load state,
// a valid body is loaded, runs the gravity (if on) and position steps on the
// shared multiplier, then the three-stage box test per box slot, then emit.
// One result per valid body leaves in slot order, tlast on the final one; no
// item is taken from the queue while a tick runs.
`timescale 1ns / 1ps
`default_nettype none
module aabb_physics_step_unit #(
  parameter int NUM_BODIES = aps_pkg::NumBodiesDef,
  parameter int NUM_BOXES  = aps_pkg::NumBoxesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tuser: cmd
  input  wire logic [1:0]                   s_axis_tuser_i,
  // tdata: slot, pos_x, pos_y, vel_x, vel_y, half_x, half_y, gravity_scale,
  //        use_gravity, dt, zero pad
  input  wire logic [aps_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tdata: body_slot, out_pos_x, out_pos_y, out_vel_x, out_vel_y, grounded,
  //        zero pad
  output logic [aps_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import aps_pkg::*;

  localparam logic REG_GRAVITY_X = 1'b0;
  localparam logic REG_GRAVITY_Y = 1'b1;

  logic signed [31:0] gx_q, gy_q;
  logic               q_valid, q_ready;
  aps_item_t          q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q <= '0;
      gy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRAVITY_X: gx_q <= cfg_data_i;
        REG_GRAVITY_Y: gy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aps_front #(
    .NUM_BODIES(NUM_BODIES),
    .NUM_BOXES (NUM_BOXES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .s_cmd_i  (s_axis_tuser_i),
    .s_data_i (s_axis_tdata_i),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_item_o (q_item)
  );

  aps_engine #(
    .NUM_BODIES(NUM_BODIES),
    .NUM_BOXES (NUM_BOXES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .gravity_x_i(gx_q),
    .gravity_y_i(gy_q),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_item_i   (q_item),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

FILE: bench/tb_aabb_physics_step_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_physics_step_unit
// self-checking bench for the aabb physics step unit
// ----------------------------------------------------------------------------
// A directed table covers field extremes, saturation, out-of-range slots, the
// unknown command, axis ties and push directions. Random loads and ticks then
// run under several gravity settings. Every tick's body reports are predicted
// by a fixed-point model of the unit and compared field by field.
`timescale 1ns / 1ps
`default_nettype none
module tb_aabb_physics_step_unit;
  import aps_pkg::*;

  localparam int NBODY = NumBodiesDef;
  localparam int NBOX = NumBoxesDef;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_GUARD = 64;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic REG_GRAV_X = 1'b0;
  localparam logic REG_GRAV_Y = 1'b1;
  localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S_MIN = 32'sh80000000;
  localparam logic [30:0] H_MAX = 31'h7fffffff;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] slot;
    logic signed [31:0] px, py, vx, vy;
    logic [30:0] hx, hy;
    logic signed [15:0] gs;
    logic gon;
    logic [15:0] dt;
  } cmd_item_t;

  typedef struct {
    logic [5:0] slot;
    logic signed [31:0] px, py, vx, vy;
    logic grounded;
    logic last;
  } body_report_t;

  typedef struct {
    cmd_item_t it;
    bit typed;
    body_report_t rep;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [1:0] s_axis_tuser_i = '0;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic m_axis_tlast_o;

  aabb_physics_step_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // world model
  logic signed [31:0] grav_x, grav_y;
  bit b_on[NBODY];
  logic signed [31:0] b_px[NBODY], b_py[NBODY], b_vx[NBODY], b_vy[NBODY];
  logic [30:0] b_hx[NBODY], b_hy[NBODY];
  logic signed [15:0] b_gs[NBODY];
  bit b_gon[NBODY], b_gnd[NBODY];
  bit x_on[NBOX];
  logic signed [31:0] x_px[NBOX], x_py[NBOX];
  logic [30:0] x_hx[NBOX], x_hy[NBOX];

  body_report_t pending_reports[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > longint'(S_MAX)) return S_MAX;
    if (x < longint'(S_MIN)) return S_MIN;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] grav_kick(logic signed [31:0] v,
      logic signed [31:0] g, logic signed [15:0] s, logic [15:0] dt);
    longint gsc, dv;
    gsc = (longint'(g) * longint'(s)) >>> 8;
    dv = (gsc * longint'({1'b0, dt})) >>> 16;
    return clamp32(longint'(v) + dv);
  endfunction

  // applies one command to the world model, queues any body reports
  function automatic void step_world(cmd_item_t it, ref body_report_t reps[$]);
    longint dt, dx, dy, ox, oy;
    body_report_t r;
    reps = {};
    dt = longint'({1'b0, it.dt});
    if (it.cmd == CMD_LOAD_BODY) begin
      if (it.slot < NBODY) begin
        b_on[it.slot] = 1; b_px[it.slot] = it.px; b_py[it.slot] = it.py;
        b_vx[it.slot] = it.vx; b_vy[it.slot] = it.vy; b_hx[it.slot] = it.hx;
        b_hy[it.slot] = it.hy; b_gs[it.slot] = it.gs; b_gon[it.slot] = it.gon;
        b_gnd[it.slot] = 0;
      end
      return;
    end
    if (it.cmd == CMD_LOAD_BOX) begin
      if (it.slot < NBOX) begin
        x_on[it.slot] = 1; x_px[it.slot] = it.px; x_py[it.slot] = it.py;
        x_hx[it.slot] = it.hx; x_hy[it.slot] = it.hy;
      end
      return;
    end
    if (it.cmd != CMD_TICK) return;
    for (int i = 0; i < NBODY; i++) begin
      if (!b_on[i]) continue;
      b_gnd[i] = 0;
      if (b_gon[i]) begin
        b_vx[i] = grav_kick(b_vx[i], grav_x, b_gs[i], it.dt);
        b_vy[i] = grav_kick(b_vy[i], grav_y, b_gs[i], it.dt);
      end
      b_px[i] = clamp32(longint'(b_px[i]) + ((longint'(b_vx[i]) * dt) >>> 16));
      b_py[i] = clamp32(longint'(b_py[i]) + ((longint'(b_vy[i]) * dt) >>> 16));
    end
    for (int i = 0; i < NBODY; i++) begin
      if (!b_on[i]) continue;
      for (int j = 0; j < NBOX; j++) begin
        if (!x_on[j]) continue;
        dx = longint'(b_px[i]) - longint'(x_px[j]);
        dy = longint'(b_py[i]) - longint'(x_py[j]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        ox = longint'({1'b0, b_hx[i]}) + longint'({1'b0, x_hx[j]}) - dx;
        oy = longint'({1'b0, b_hy[i]}) + longint'({1'b0, x_hy[j]}) - dy;
        if (ox <= 0 || oy <= 0) continue;
        // y only wins when strictly shallower; equal centres push negative
        if (oy < ox) begin
          if (b_py[i] > x_py[j]) begin
            b_py[i] = clamp32(longint'(b_py[i]) + oy);
            b_gnd[i] = 1;
          end else begin
            b_py[i] = clamp32(longint'(b_py[i]) - oy);
          end
          b_vy[i] = 0;
        end else begin
          if (b_px[i] > x_px[j]) b_px[i] = clamp32(longint'(b_px[i]) + ox);
          else b_px[i] = clamp32(longint'(b_px[i]) - ox);
          b_vx[i] = 0;
        end
      end
    end
    for (int i = 0; i < NBODY; i++) begin
      if (!b_on[i]) continue;
      r.slot = i[5:0]; r.px = b_px[i]; r.py = b_py[i]; r.vx = b_vx[i];
      r.vy = b_vy[i]; r.grounded = b_gnd[i]; r.last = 0;
      reps.insert(reps.size(), r);
    end
    if (reps.size() > 0) reps[reps.size()-1].last = 1;
  endfunction

  function automatic cmd_item_t mk(logic [1:0] cmd, logic [7:0] slot,
      logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] vx,
      logic signed [31:0] vy, logic [30:0] hx, logic [30:0] hy,
      logic signed [15:0] gs, logic gon, logic [15:0] dt);
    cmd_item_t it;
    it.cmd = cmd; it.slot = slot; it.px = px; it.py = py; it.vx = vx;
    it.vy = vy; it.hx = hx; it.hy = hy; it.gs = gs; it.gon = gon; it.dt = dt;
    return it;
  endfunction

  function automatic logic signed [31:0] rnd_coord();
    if ($urandom_range(0, 11) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  function automatic logic [30:0] rnd_half();
    if ($urandom_range(0, 11) == 0) return 31'($urandom);
    return 31'($urandom_range(32'h0000_4000, 32'h0008_0000));
  endfunction

  function automatic cmd_item_t rnd_item();
    cmd_item_t it;
    int k;
    k = $urandom_range(0, 99);
    it.px = rnd_coord(); it.py = rnd_coord();
    it.vx = ($urandom_range(0, 9) == 0) ? $urandom
          : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    it.vy = ($urandom_range(0, 9) == 0) ? $urandom
          : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    it.hx = rnd_half(); it.hy = rnd_half();
    it.gs = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
    it.gon = 1'($urandom);
    it.dt = ($urandom_range(0, 7) == 0) ? 16'($urandom)
          : 16'($urandom_range(0, 16'h1000));
    if (k < 38) begin
      it.cmd = CMD_LOAD_BODY; it.slot = 8'($urandom_range(0, NBODY - 1));
    end else if (k < 62) begin
      it.cmd = CMD_LOAD_BOX; it.slot = 8'($urandom_range(0, NBOX - 1));
    end else if (k < 90) begin
      it.cmd = CMD_TICK; it.slot = 8'($urandom);
    end else if (k < 95) begin
      it.cmd = 2'($urandom_range(0, 1));
      it.slot = 8'($urandom_range(it.cmd == CMD_LOAD_BODY ? NBODY : NBOX, 255));
    end else begin
      it.cmd = CMD_NONE; it.slot = 8'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(cmd_item_t it);
    body_report_t reps[$];
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= it.cmd;
    s_axis_tdata_i <= {1'b0, it.dt, it.gon, it.gs, it.hy, it.hx,
                       it.vy, it.vx, it.py, it.px, it.slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    step_world(it, reps);
    foreach (reps[i]) pending_reports.insert(pending_reports.size(), reps[i]);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() > 0) @(negedge clk_i);
    repeat (IDLE_GUARD) @(negedge clk_i);
  endtask

  task automatic write_gravity(logic signed [31:0] gx, logic signed [31:0] gy);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_GRAV_X; cfg_data_i <= gx;
    @(negedge clk_i);
    cfg_idx_i <= REG_GRAV_Y; cfg_data_i <= gy;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    grav_x = gx; grav_y = gy;
  endtask

  // receiver side
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    logic rdy;
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      rdy = 1'b0;
    end else if (quiet) begin
      rdy = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready_i <= rdy;
  end

  always @(posedge clk_i) begin
    body_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_reports.size() == 0) begin
        $error("body report with none expected: slot %0d", m_axis_tdata_o[5:0]);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (m_axis_tdata_o[5:0] !== want.slot) begin
          $error("body_slot exp %0d got %0d", want.slot, m_axis_tdata_o[5:0]);
          errors++;
        end
        if (m_axis_tdata_o[37:6] !== want.px) begin
          $error("out_pos_x exp %h got %h", want.px, m_axis_tdata_o[37:6]);
          errors++;
        end
        if (m_axis_tdata_o[69:38] !== want.py) begin
          $error("out_pos_y exp %h got %h", want.py, m_axis_tdata_o[69:38]);
          errors++;
        end
        if (m_axis_tdata_o[101:70] !== want.vx) begin
          $error("out_vel_x exp %h got %h", want.vx, m_axis_tdata_o[101:70]);
          errors++;
        end
        if (m_axis_tdata_o[133:102] !== want.vy) begin
          $error("out_vel_y exp %h got %h", want.vy, m_axis_tdata_o[133:102]);
          errors++;
        end
        if (m_axis_tdata_o[134] !== want.grounded) begin
          $error("grounded exp %0d got %0d", want.grounded, m_axis_tdata_o[134]);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last exp %0d got %0d", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("aabb_physics_step_unit test failed");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t row;
    logic signed [31:0] gsets[4][2];

    grav_x = 0; grav_y = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    row.typed = 0;
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h1234);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BODY, 15, S_MAX, S_MIN, S_MIN, S_MAX, H_MAX, H_MAX,
                16'sh8000, 1, 0);
    rows.insert(rows.size(), row);
    // zero step keeps the extreme body untouched
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1;
    row.rep = '{slot: 15, px: S_MAX, py: S_MIN, vx: S_MIN, vy: S_MAX,
                grounded: 0, last: 1};
    rows.insert(rows.size(), row);
    row.typed = 0;
    row.it = mk(CMD_TICK, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BODY, 16, 1, 1, 1, 1, 1, 1, 1, 1, 1);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BODY, 255, -1, -1, -1, -1, H_MAX, H_MAX, -1, 1, 16'hffff);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BOX, 32, 0, 0, 0, 0, H_MAX, H_MAX, 0, 0, 0);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_NONE, 0, 0, 0, 0, 0, H_MAX, H_MAX, 0, 1, 16'h0100);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BOX, 31, 0, 0, 0, 0, 31'h000a_0000, 31'h000a_0000, 0, 0, 0);
    rows.insert(rows.size(), row);
    // landing on top of the box
    row.it = mk(CMD_LOAD_BODY, 0, 0, 32'sh000b_0000, 0, -32'sh0001_0000,
                31'h0001_0000, 31'h0001_0000, 16'sh0100, 1, 0);
    rows.insert(rows.size(), row);
    // side body moves clear of the box before the test, no x push
    row.it = mk(CMD_LOAD_BODY, 1, 32'sh000a_8000, 0, 32'sh0002_0000, 0,
                31'h0001_0000, 31'h0001_0000, 0, 0, 0);
    rows.insert(rows.size(), row);
    // centred body, equal overlaps: x push, negative
    row.it = mk(CMD_LOAD_BODY, 2, 0, 0, 0, 0, 31'h0001_0000, 31'h0001_0000, 0, 0, 0);
    rows.insert(rows.size(), row);
    // underneath the box pushes down
    row.it = mk(CMD_LOAD_BODY, 3, 32'sh0000_4000, -32'sh000a_8000, 0, 32'sh0001_0000,
                31'h0004_0000, 31'h0001_0000, 0, 0, 0);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h8000);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BODY, 0, 0, 32'sh000b_0000, 0, -32'sh0001_0000,
                31'h0001_0000, 31'h0001_0000, 16'sh0100, 1, 0);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_LOAD_BOX, 0, S_MAX, S_MIN, 0, 0, H_MAX, H_MAX, 0, 0, 0);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hffff);
    rows.insert(rows.size(), row);
    row.it = mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0001);
    rows.insert(rows.size(), row);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send_item(rows[i].it);
        // typed value replaces the modelled report of this row
        if (rows[i].it.dt == 0 && pending_reports.size() > 0 && rows[i].rep.last) begin
          void'(pending_reports.pop_back());
          pending_reports.insert(pending_reports.size(), rows[i].rep);
        end
        rows[i].rep.last = 0;
      end else begin
        send_item(rows[i].it);
      end
    end
    settle();

    gsets[0] = '{-32'sd642253, 32'sh0003_0000};
    gsets[1] = '{S_MAX, S_MIN};
    gsets[2] = '{S_MIN, S_MAX};
    gsets[3] = '{$urandom, -$signed({16'd0, 16'($urandom)}) <<< 4};
    for (int p = 0; p < 4; p++) begin
      write_gravity(gsets[p][0], gsets[p][1]);
      if (p == 3) quiet = 1'b1;
      for (int n = 0; n < 88; n++) begin
        if (p == 1 && n == 30) hold_req = 1'b1;
        send_item(rnd_item());
      end
      // sender waits for every report before the next gravity setting
      settle();
    end
    write_gravity(0, 0);
    send_item(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0400));
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("aabb_physics_step_unit test passed");
    end else begin
      $display("aabb_physics_step_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/aps_pkg.sv
hdl/aps_front.sv
hdl/aps_engine.sv
hdl/aabb_physics_step_unit.sv
bench/tb_aabb_physics_step_unit.sv
